@@ rtl/qwt_pkg.sv @@
// shared types, constants and helpers for the quoted word tokenizer
package qwt_pkg;

  // default sizing of the top level
  localparam int unsigned LineMaxDef      = 1024;
  localparam int unsigned MaxWordsDef     = 32;
  localparam int unsigned MaxWordBytesDef = 256;

  // result queue depth, room is needed for three results per item
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // register reset values
  localparam logic [8:0] WordBufBytesRst = 9'd64;
  localparam logic [5:0] WordLimitRst    = 6'd16;

  // register indexes on the configuration port
  localparam logic RegWordBufBytes = 1'b0;
  localparam logic RegWordLimit    = 1'b1;

  // special characters
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChBSlash = 8'h5C;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_LINE  = 2'd2
  } qwt_kind_e;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2
  } qwt_quote_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] in_byte;
    logic       line_end;
  } qwt_in_t;

  typedef struct packed {
    qwt_kind_e  kind;
    logic [4:0] word_index;
    logic [7:0] char_offset;
    logic [9:0] start_pos;
    logic [7:0] out_byte;
    logic       ok;
    logic       blank_tail;
    logic [5:0] word_count;
    logic       last;
  } qwt_out_t;

  // results of one item headed for the queue
  typedef struct packed {
    logic [1:0]         n;
    qwt_out_t [2:0]     res;
  } qwt_push_t;

  // live register values
  typedef struct packed {
    logic [8:0] word_buf_bytes;
    logic [5:0] word_limit;
  } qwt_cfg_t;

  // C-locale whitespace: space, tab, LF, VT, FF, CR
  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

@@ rtl/qwt_regs.sv @@
// configuration registers behind the apb port
module qwt_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output qwt_pkg::qwt_cfg_t cfg_o
);
  import qwt_pkg::*;

  logic [8:0] wbb_q;
  logic [5:0] wlim_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbb_q  <= WordBufBytesRst;
      wlim_q <= WordLimitRst;
    end else if (wr_en) begin
      if (paddr[2] == RegWordBufBytes) begin
        wbb_q <= pwdata[8:0];
      end else begin
        wlim_q <= pwdata[5:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == RegWordBufBytes) begin
      prdata = {23'd0, wbb_q};
    end else begin
      prdata = {26'd0, wlim_q};
    end
  end

  assign cfg_o.word_buf_bytes = wbb_q;
  assign cfg_o.word_limit     = wlim_q;

endmodule

@@ rtl/qwt_core.sv @@
// input register, per-line state and the one-pass tokenizing step
module qwt_core #(
  parameter int unsigned LINE_MAX       = qwt_pkg::LineMaxDef,
  parameter int unsigned MAX_WORDS      = qwt_pkg::MaxWordsDef,
  parameter int unsigned MAX_WORD_BYTES = qwt_pkg::MaxWordBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qwt_pkg::qwt_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qwt_pkg::qwt_in_t   in_data_i,
  input  logic               room_i,
  output qwt_pkg::qwt_push_t push_o
);
  import qwt_pkg::*;

  localparam int unsigned LPW = $clog2(LINE_MAX + 1);
  localparam logic [LPW-1:0] LineMaxC = LPW'(LINE_MAX);
  localparam logic [8:0] SizeCap  = (MAX_WORD_BYTES > 511) ? 9'd511 : 9'(MAX_WORD_BYTES);
  localparam logic [5:0] LimitCap = (MAX_WORDS > 63) ? 6'd63 : 6'(MAX_WORDS);

  // input register
  logic    vld_q;
  qwt_in_t in_q;
  logic    take;
  logic    process;

  // per-line state
  logic [LPW-1:0] line_pos_q, line_pos_d;
  logic           in_word_q, in_word_d;
  qwt_quote_e     quote_q, quote_d;
  logic           esc_q, esc_d;
  logic [5:0]     words_q, words_d;
  logic [8:0]     wlen_q, wlen_d;
  logic [LPW-1:0] wstart_q, wstart_d;
  logic           failed_q, failed_d;
  logic           eos_q, eos_d;

  logic [8:0] eff_size;
  logic [5:0] eff_limit;
  logic [1:0] n;
  qwt_out_t [2:0] res;

  assign eff_size   = (cfg_i.word_buf_bytes > SizeCap) ? SizeCap : cfg_i.word_buf_bytes;
  assign eff_limit  = (cfg_i.word_limit > LimitCap) ? LimitCap : cfg_i.word_limit;
  assign process    = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (process) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
  end

  // one item: optional byte, then optional line end
  always_comb begin : step
    logic [LPW+9:0] st_ext;
    logic           skip;
    logic           do_emit;
    logic           do_close;
    logic [7:0]     ch;
    logic           ws;

    line_pos_d = line_pos_q;
    in_word_d  = in_word_q;
    quote_d    = quote_q;
    esc_d      = esc_q;
    words_d    = words_q;
    wlen_d     = wlen_q;
    wstart_d   = wstart_q;
    failed_d   = failed_q;
    eos_d      = eos_q;
    n          = 2'd0;
    res        = '0;
    skip       = 1'b0;
    do_emit    = 1'b0;
    do_close   = 1'b0;
    ch         = in_q.in_byte;
    ws         = is_ws(ch);
    st_ext     = '0;

    if ((eff_size == 9'd0) || (eff_limit == 6'd0)) begin
      failed_d = 1'b1;
    end

    // byte handling
    if (in_q.has_byte && !failed_d) begin
      if (line_pos_d >= LineMaxC) begin
        failed_d = 1'b1;
      end else begin
        if (!in_word_d) begin
          if (ws) begin
            eos_d = 1'b1;
            skip  = 1'b1;
          end else if (words_d >= eff_limit) begin
            failed_d = 1'b1;
            skip     = 1'b1;
          end else begin
            in_word_d = 1'b1;
            wstart_d  = line_pos_d;
            wlen_d    = 9'd0;
            quote_d   = QM_NONE;
            esc_d     = 1'b0;
          end
        end
        line_pos_d = line_pos_d + LPW'(1);
        if (!skip) begin
          if (esc_d) begin
            esc_d   = 1'b0;
            eos_d   = 1'b0;
            do_emit = 1'b1;
          end else if ((quote_d == QM_NONE) && ws) begin
            eos_d    = 1'b1;
            do_close = 1'b1;
          end else begin
            eos_d = 1'b0;
            if ((ch == ChSQuote) && ((quote_d == QM_NONE) || (quote_d == QM_SINGLE))) begin
              quote_d = (quote_d == QM_NONE) ? QM_SINGLE : QM_NONE;
            end else if ((ch == ChDQuote) &&
                         ((quote_d == QM_NONE) || (quote_d == QM_DOUBLE))) begin
              quote_d = (quote_d == QM_NONE) ? QM_DOUBLE : QM_NONE;
            end else if ((ch == ChBSlash) && (quote_d != QM_SINGLE)) begin
              esc_d = 1'b1;
            end else begin
              do_emit = 1'b1;
            end
          end
        end
      end
    end

    st_ext = {10'd0, wstart_d};

    // word byte from the byte itself
    if (do_emit) begin
      if (({1'b0, wlen_d} + 10'd1) >= {1'b0, eff_size}) begin
        failed_d = 1'b1;
      end else begin
        res[n] = '{kind: KIND_BYTE, word_index: words_d[4:0], char_offset: wlen_d[7:0],
                   start_pos: st_ext[9:0], out_byte: ch, ok: 1'b0, blank_tail: 1'b0,
                   word_count: 6'd0, last: 1'b0};
        n      = n + 2'd1;
        wlen_d = wlen_d + 9'd1;
      end
    end

    // word closed by unquoted whitespace
    if (do_close) begin
      res[n] = '{kind: KIND_CLOSE, word_index: words_d[4:0], char_offset: wlen_d[7:0],
                 start_pos: st_ext[9:0], out_byte: 8'd0, ok: 1'b0, blank_tail: 1'b0,
                 word_count: 6'd0, last: 1'b0};
      n         = n + 2'd1;
      words_d   = words_d + 6'd1;
      in_word_d = 1'b0;
      quote_d   = QM_NONE;
      esc_d     = 1'b0;
      wlen_d    = 9'd0;
    end

    // line end: flush a dangling backslash, close the open word, report
    if (in_q.line_end) begin
      if (!failed_d && in_word_d) begin
        if (esc_d) begin
          esc_d = 1'b0;
          if (({1'b0, wlen_d} + 10'd1) >= {1'b0, eff_size}) begin
            failed_d = 1'b1;
          end else begin
            res[n] = '{kind: KIND_BYTE, word_index: words_d[4:0], char_offset: wlen_d[7:0],
                       start_pos: st_ext[9:0], out_byte: ChBSlash, ok: 1'b0,
                       blank_tail: 1'b0, word_count: 6'd0, last: 1'b0};
            n      = n + 2'd1;
            wlen_d = wlen_d + 9'd1;
          end
        end
        if (!failed_d) begin
          res[n] = '{kind: KIND_CLOSE, word_index: words_d[4:0], char_offset: wlen_d[7:0],
                     start_pos: st_ext[9:0], out_byte: 8'd0, ok: 1'b0,
                     blank_tail: 1'b0, word_count: 6'd0, last: 1'b0};
          n       = n + 2'd1;
          words_d = words_d + 6'd1;
        end
      end
      res[n] = '{kind: KIND_LINE, word_index: 5'd0, char_offset: 8'd0, start_pos: 10'd0,
                 out_byte: 8'd0, ok: !failed_d, blank_tail: !failed_d && eos_d,
                 word_count: words_d, last: 1'b0};
      n          = n + 2'd1;
      line_pos_d = '0;
      in_word_d  = 1'b0;
      quote_d    = QM_NONE;
      esc_d      = 1'b0;
      words_d    = 6'd0;
      wlen_d     = 9'd0;
      wstart_d   = '0;
      failed_d   = 1'b0;
      eos_d      = 1'b0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  // state register, advanced once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos_q <= '0;
      in_word_q  <= 1'b0;
      quote_q    <= QM_NONE;
      esc_q      <= 1'b0;
      words_q    <= 6'd0;
      wlen_q     <= 9'd0;
      wstart_q   <= '0;
      failed_q   <= 1'b0;
      eos_q      <= 1'b0;
    end else if (process) begin
      line_pos_q <= line_pos_d;
      in_word_q  <= in_word_d;
      quote_q    <= quote_d;
      esc_q      <= esc_d;
      words_q    <= words_d;
      wlen_q     <= wlen_d;
      wstart_q   <= wstart_d;
      failed_q   <= failed_d;
      eos_q      <= eos_d;
    end
  end

  assign push_o.n   = process ? n : 2'd0;
  assign push_o.res = res;

  // last result of an item carries the last flag
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && (n != 2'd0)) |-> res[n - 2'd1].last)
    else $error("last flag missing on final result");

  // a line end always produces the line-finished result
  a_line_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_q.line_end) |-> (n != 2'd0) && (res[n - 2'd1].kind == KIND_LINE))
    else $error("line end without line-finished result");

  // per-line state is clear after a line end
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_q.line_end) |=> (line_pos_q == '0) && !in_word_q && !failed_q &&
                                   (words_q == 6'd0))
    else $error("line state not cleared");

endmodule

@@ rtl/qwt_queue.sv @@
// small result queue that takes up to three results and sends one per cycle while out_ready_i is high
module qwt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qwt_pkg::qwt_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qwt_pkg::qwt_out_t  out_data_o
);
  import qwt_pkg::*;

  qwt_out_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_q <= QCntW'(QDepth - 3));
  assign count_d     = count_q + QCntW'(push_i.n) - QCntW'(pop);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      count_q  <= count_d;
    end
  end

  // entry writes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.n) begin
        mem_q[wr_ptr_q + QPtrW'(i)] <= push_i.res[i];
      end
    end
  end

  // fill count never passes the depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // pushes only arrive when room was granted
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("push without room");

  // a pop with no push shrinks the count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.n == 2'd0)) |=> (count_q == $past(count_q) - QCntW'(1)))
    else $error("queue count mismatch on pop");

endmodule

@@ rtl/quoted_word_tokenizer.sv @@
// top level of the quoted word tokenizer
// Splits a command line, fed one byte per transaction, into shell-style words.
// Input channel: in_valid_i/in_ready_o with in_data_i (has_byte, in_byte,
// line_end). Output channel: out_valid_o/out_ready_i with out_data_o, one
// result per transaction: word byte, word closed or line finished, with last
// set on the final result of an input item. Registers word_buf_bytes (0x0)
// and word_limit (0x4) sit behind the apb port; the user is to write them
// only while idle, which the block itself does not enforce. An item is
// captured in the input register, processed into the result queue once the
// queue has room, and its first result is then offered from the queue.
// Throughput: one item per cycle while each item yields at most one result and
// the receiver is ready, as the queue drains one result per cycle; items with
// more results slow intake; input is taken when the queue fits three results.
// Reset clears the line state and the queue and loads the register defaults.
// When the receiver stalls, results wait in the queue and input is held off
// once the queue lacks room for a full item.
module quoted_word_tokenizer #(
  parameter int unsigned LINE_MAX       = qwt_pkg::LineMaxDef,
  parameter int unsigned MAX_WORDS      = qwt_pkg::MaxWordsDef,
  parameter int unsigned MAX_WORD_BYTES = qwt_pkg::MaxWordBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qwt_pkg::qwt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qwt_pkg::qwt_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import qwt_pkg::*;

  qwt_cfg_t  cfg;
  qwt_push_t push;
  logic      room;

  qwt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qwt_core #(
    .LINE_MAX       (LINE_MAX),
    .MAX_WORDS      (MAX_WORDS),
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  qwt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
